@@ rtl/wpwr_pkg.sv @@
// ----------------------------------------------------------------------------
// wpwr_pkg
// shared types and constants for the weighted pick block
// ----------------------------------------------------------------------------
package wpwr_pkg;

    localparam int unsigned MaxNodesDef   = 64;
    localparam int unsigned WeightBitsDef = 32;
    localparam int unsigned OfsW          = 38;
    localparam int unsigned PosW          = 6;
    localparam int unsigned CntW          = 7;
    localparam int unsigned SeedW         = 256;

    localparam logic [1:0] OpLoadWeight = 2'd0;
    localparam logic [1:0] OpLoadSeed   = 2'd1;
    localparam logic [1:0] OpSelect     = 2'd2;
    localparam logic [1:0] OpUnused     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_SRCH_RD,
        S_SRCH,
        S_PREV,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT,
        S_EMPTY
    } t_state;

endpackage

@@ rtl/wpwr_mod.sv @@
// ----------------------------------------------------------------------------
// wpwr_mod
// bit-serial 256-bit seed modulo a 38-bit divisor, one seed bit per cycle
// ----------------------------------------------------------------------------
module wpwr_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wpwr_pkg::SeedW-1:0]  i_seed,
    input  logic [wpwr_pkg::OfsW-1:0]   i_div,
    output logic                        o_done,
    output logic [wpwr_pkg::OfsW-1:0]   o_rem
);
    import wpwr_pkg::*;

    logic [SeedW-1:0] r_sh;
    logic [OfsW-1:0]  r_rem;
    logic [8:0]       r_cnt;
    logic             r_busy;
    logic [OfsW:0]    n_trial;

    // shift in next seed bit and conditionally subtract
    always_comb begin
        n_trial = {r_rem, r_sh[SeedW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_sh   <= i_seed;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_sh <= {r_sh[SeedW-2:0], 1'b0};
            if (n_trial >= {1'b0, i_div}) begin
                r_rem <= OfsW'(n_trial - {1'b0, i_div});
            end else begin
                r_rem <= OfsW'(n_trial);
            end
            r_cnt <= r_cnt + 9'd1;
            if (r_cnt == 9'(SeedW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 9'(SeedW - 1));
    assign o_rem  = (n_trial >= {1'b0, i_div}) ? OfsW'(n_trial - {1'b0, i_div})
                                               : OfsW'(n_trial);

endmodule

@@ rtl/wpwr_mem.sv @@
// ----------------------------------------------------------------------------
// wpwr_mem
// offset and position table, one write and one registered read port
// ----------------------------------------------------------------------------
module wpwr_mem #(
    parameter int unsigned MAX_NODES = wpwr_pkg::MaxNodesDef
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(MAX_NODES)-1:0]   i_waddr,
    input  logic [wpwr_pkg::OfsW-1:0]      i_wofs,
    input  logic [wpwr_pkg::PosW-1:0]      i_wpos,
    input  logic [$clog2(MAX_NODES)-1:0]   i_raddr,
    output logic [wpwr_pkg::OfsW-1:0]      o_rofs,
    output logic [wpwr_pkg::PosW-1:0]      o_rpos
);
    import wpwr_pkg::*;

    logic [OfsW+PosW-1:0] r_mem [MAX_NODES];
    logic [OfsW+PosW-1:0] r_rd;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wofs, i_wpos};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rofs = r_rd[OfsW+PosW-1:PosW];
    assign o_rpos = r_rd[PosW-1:0];

endmodule

@@ rtl/weighted_pick_without_replacement_top.sv @@
// ----------------------------------------------------------------------------
// weighted_pick_without_replacement_top
// weighted sampling without replacement over a memory-held offset table
// ----------------------------------------------------------------------------
// channel | dir | signals
// in      | in  | i_valid, o_stall, i_op, i_weight, i_seed_word, i_seed_slot
// out     | out | o_valid, i_stall, o_node_position, o_picked, o_overflow, o_last
// cfg     | in  | i_cfg_we, i_cfg_wdata (epoch_size)
//
// a load is accepted and applied in S_IDLE; a select runs one pick at a time
// each pick: the serial seed modulo, a table scan of one entry per cycle through
// the registered read port, then a shift through S_SHIFT_RD, S_SHIFT_WR per entry
// reset is synchronous and clears all control state; the table needs no clear
// output beats wait in a register while i_stall is high
// ----------------------------------------------------------------------------
module weighted_pick_without_replacement_top #(
    parameter int unsigned MAX_NODES   = wpwr_pkg::MaxNodesDef,
    parameter int unsigned WEIGHT_BITS = wpwr_pkg::WeightBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_weight,
    input  logic [63:0] i_seed_word,
    input  logic [1:0]  i_seed_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_node_position,
    output logic        o_picked,
    output logic        o_overflow,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);
    import wpwr_pkg::*;

    localparam int unsigned AW = $clog2(MAX_NODES);

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_epoch;
    logic [CntW-1:0]  r_cnt, r_ld, r_left, r_i;
    logic [OfsW-1:0]  r_total, r_idx, r_wt;
    logic [63:0]      r_seed [4];
    logic             r_ovf;
    logic [AW-1:0]    r_k;
    logic [PosW-1:0]  r_pos;
    logic             r_oval, r_opick, r_olast;
    logic [PosW-1:0]  r_opos;

    logic             acc, out_free;
    logic [OfsW-1:0]  wmask;
    logic             mod_start, mod_done;
    logic [OfsW-1:0]  mod_rem;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [OfsW-1:0]  wofs, rofs;
    logic [PosW-1:0]  wpos, rpos;
    logic [CntW-1:0]  n_pick;

    assign out_free = !r_oval || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && !o_stall;
    assign wmask    = OfsW'(i_weight[WEIGHT_BITS-1:0]);
    assign n_pick   = (r_epoch < r_cnt) ? r_epoch : r_cnt;

    wpwr_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_seed  ({r_seed[3], r_seed[2], r_seed[1], r_seed[0]}),
        .i_div   (r_total),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    wpwr_mem #(.MAX_NODES(MAX_NODES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wofs  (wofs),
        .i_wpos  (wpos),
        .i_raddr (raddr),
        .o_rofs  (rofs),
        .o_rpos  (rpos)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && i_op == OpSelect) begin
                    if (n_pick == '0 || r_total == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD:      if (mod_done) n_state = S_SRCH_RD;
            S_SRCH_RD:  n_state = S_SRCH;
            S_SRCH: begin
                if (rofs >= r_idx || r_i + 7'd1 >= r_cnt) begin
                    n_state = (r_i == '0) ? S_SHIFT_RD : S_PREV;
                end
            end
            S_PREV:     n_state = S_SHIFT_RD;
            S_SHIFT_RD: n_state = (7'(r_k) + 7'd1 >= r_cnt) ? S_EMIT : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_EMIT:     if (out_free) n_state = (r_left == 7'd1) ? S_IDLE : S_MOD;
            S_EMPTY:    if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory and modulo control
    always_comb begin
        mod_start = 1'b0;
        we        = 1'b0;
        waddr     = r_cnt[AW-1:0];
        wofs      = OfsW'(r_total + wmask);
        wpos      = r_ld[PosW-1:0];
        raddr     = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mod_start = acc && i_op == OpSelect;
                we = acc && i_op == OpLoadWeight && r_ld < 7'(MAX_NODES)
                     && wmask != '0 && r_cnt < 7'(MAX_NODES);
            end
            S_SRCH: begin
                raddr = (rofs >= r_idx || r_i + 7'd1 >= r_cnt)
                      ? AW'(r_i - 7'd1) : AW'(r_i + 7'd1);
            end
            S_PREV:     raddr = AW'(7'(r_k) + 7'd1);
            S_SHIFT_RD: raddr = AW'(7'(r_k) + 7'd1);
            S_SHIFT_WR: begin
                we    = 1'b1;
                waddr = r_k;
                wofs  = OfsW'(rofs - r_wt);
                wpos  = rpos;
                raddr = AW'(7'(r_k) + 7'd2);
            end
            S_EMIT:     mod_start = out_free && r_left != 7'd1;
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_epoch <= '0;
            r_cnt   <= '0;
            r_ld    <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
            for (int s = 0; s < 4; s++) r_seed[s] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_epoch <= i_cfg_wdata;
            if (r_oval && !i_stall && r_state != S_EMIT && r_state != S_EMPTY) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && i_op == OpLoadWeight) begin
                        if (r_ld >= 7'(MAX_NODES)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            if (we) begin
                                r_total <= OfsW'(r_total + wmask);
                                r_cnt   <= r_cnt + 7'd1;
                            end
                            r_ld <= r_ld + 7'd1;
                        end
                    end else if (acc && i_op == OpLoadSeed) begin
                        r_seed[i_seed_slot] <= i_seed_word;
                    end else if (acc && i_op == OpSelect) begin
                        r_left <= n_pick;
                    end
                end
                S_MOD: begin
                    r_idx <= mod_rem;
                    r_i   <= '0;
                end
                S_SRCH_RD: ;
                S_SRCH: begin
                    if (rofs >= r_idx || r_i + 7'd1 >= r_cnt) begin
                        r_k   <= r_i[AW-1:0];
                        r_pos <= rpos;
                        r_wt  <= rofs;
                    end else begin
                        r_i <= r_i + 7'd1;
                    end
                end
                S_PREV: r_wt <= OfsW'(r_wt - rofs);
                S_SHIFT_RD: ;
                S_SHIFT_WR: r_k <= r_k + AW'(1);
                S_EMIT: begin
                    if (out_free) begin
                        r_oval  <= 1'b1;
                        r_opos  <= r_pos;
                        r_opick <= 1'b1;
                        r_olast <= (r_left == 7'd1);
                        r_left  <= r_left - 7'd1;
                        if (r_left == 7'd1) begin
                            r_cnt   <= '0;
                            r_ld    <= '0;
                            r_total <= '0;
                            r_ovf   <= 1'b0;
                        end else begin
                            r_total <= OfsW'(r_total - r_wt);
                            r_cnt   <= r_cnt - 7'd1;
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_oval  <= 1'b1;
                        r_opos  <= '0;
                        r_opick <= 1'b0;
                        r_olast <= 1'b1;
                        r_cnt   <= '0;
                        r_ld    <= '0;
                        r_total <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // overflow flag captured with the beat
    logic r_oovf;
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT || r_state == S_EMPTY) && out_free) r_oovf <= r_ovf;
    end

    assign o_valid         = r_oval;
    assign o_node_position = r_opos;
    assign o_picked        = r_opick;
    assign o_overflow      = r_oovf;
    assign o_last          = r_olast;

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'(MAX_NODES)) else $error("entry count past capacity");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_picked) |-> o_last) else $error("empty beat not last");

endmodule
